[rtl/core/xrrg_pkg.sv]
package xrrg_pkg;

	// Request codes on the operation port (code 3 is ignored)
	typedef enum logic [1:0] {
		OP_SEED  = 2'd0,
		OP_NEXT  = 2'd1,
		OP_RANGE = 2'd2
	} op_t;

	// xorshift64* output multiplier
	localparam logic [63:0] MULT_CONST = 64'd2685821657736338717;

	// Seed hash runs in four steps, one per cycle
	localparam int          HASH_STEP_W = 2;
	localparam logic [HASH_STEP_W-1:0] HASH_FIRST = 2'd0;
	localparam logic [HASH_STEP_W-1:0] HASH_LAST  = 2'd3;

	// Request passed from the front end to the back end
	typedef struct packed {
		logic               is_range;
		logic [63:0]        gen_state;
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
	} req_t;

	// One step of the 64-bit shift/add integer hash
	function automatic logic [63:0] hash_stage(input logic [63:0] k,
	                                           input logic [HASH_STEP_W-1:0] stage);
		logic [63:0] t;
		logic [63:0] r;
		t = k;
		r = k;
		case (stage)
			2'd0: begin
				r = ~k + (k << 21);
			end
			2'd1: begin
				t = k ^ (k >> 24);
				r = t + (t << 3) + (t << 8);
			end
			2'd2: begin
				t = k ^ (k >> 14);
				r = t + (t << 2) + (t << 4);
			end
			default: begin
				t = k ^ (k >> 28);
				r = t + (t << 31);
			end
		endcase
		return r;
	endfunction

	// Full hash, evaluated at elaboration only
	function automatic logic [63:0] mix_hash(input logic [63:0] k);
		logic [63:0] r;
		r = k;
		for (int i = 0; i <= int'(HASH_LAST); i++) begin
			r = hash_stage(r, HASH_STEP_W'(i));
		end
		return r;
	endfunction

	localparam logic [63:0] HASH_ZERO = mix_hash(64'd0);

endpackage

[rtl/core/xrrg_queue.sv]
module xrrg_queue
	import xrrg_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  req_t wr_data,
	output logic full,
	input  logic rd,
	output req_t rd_data,
	output logic nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	req_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/xrrg_front.sv]
module xrrg_front
	import xrrg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         operation,
	input  logic signed [31:0] seed_value,
	input  logic signed [31:0] range_low,
	input  logic signed [31:0] range_high,
	input  logic               queue_full,
	output logic               req_wr,
	output req_t               req
);

	logic [63:0]            state_q;
	logic                   busy_q;
	logic [HASH_STEP_W-1:0] step_q;

	logic        accept;
	logic [63:0] xs1;
	logic [63:0] xs2;
	logic [63:0] xs3;
	logic [63:0] seed_ext;

	assign full     = busy_q || queue_full;
	assign accept   = push && !full;
	assign seed_ext = {{32{seed_value[31]}}, seed_value};

	// state recurrence
	assign xs1 = state_q ^ (state_q >> 12);
	assign xs2 = xs1 ^ (xs1 << 25);
	assign xs3 = xs2 ^ (xs2 >> 27);

	assign req_wr         = accept && (operation == OP_NEXT || operation == OP_RANGE);
	assign req.is_range   = (operation == OP_RANGE);
	assign req.gen_state  = xs3;
	assign req.range_low  = range_low;
	assign req.range_high = range_high;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HASH_ZERO;
			busy_q  <= 1'b0;
			step_q  <= HASH_FIRST;
		end else if (busy_q) begin
			state_q <= hash_stage(state_q, step_q);
			step_q  <= step_q + 1'b1;
			if (step_q == HASH_LAST) begin
				busy_q <= 1'b0;
			end
		end else if (accept) begin
			case (operation)
				OP_SEED: begin
					state_q <= hash_stage(seed_ext, HASH_FIRST);
					step_q  <= HASH_FIRST + 1'b1;
					busy_q  <= 1'b1;
				end
				OP_NEXT, OP_RANGE: begin
					state_q <= xs3;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/core/xrrg_back.sv]
module xrrg_back
	import xrrg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  req_t               req,
	output logic               req_pop,
	output logic               empty,
	input  logic               pop,
	output logic [51:0]        fraction,
	output logic signed [31:0] ranged_value
);

	typedef enum logic [3:0] {
		B_IDLE,
		B_M0,
		B_M1,
		B_M2,
		B_M3,
		B_FRAC,
		B_R1,
		B_R2,
		B_R3
	} bstate_t;

	bstate_t     st_q;
	logic [63:0] s_q;
	logic        is_range_q;
	logic [31:0] lo_q;
	logic        neg_q;
	logic [32:0] m_q;
	logic [65:0] prod_q;
	logic [63:0] acc_q;
	logic [51:0] frac_q;
	logic [58:0] a_q;
	logic [59:0] low_q;
	logic        out_valid_q;
	logic [51:0] fraction_q;
	logic [31:0] ranged_q;

	logic [32:0] mul_a;
	logic [32:0] mul_b;
	logic [65:0] mul_p;
	logic [33:0] span;
	logic [33:0] span_mag;
	logic        slot_free;
	logic        out_load;
	logic [31:0] q32;
	logic [31:0] q32_up;
	logic        rem;
	logic [31:0] ranged_next;

	assign req_pop      = (st_q == B_IDLE) && req_valid;
	assign empty        = !out_valid_q;
	assign fraction     = fraction_q;
	assign ranged_value = ranged_q;
	assign slot_free    = !out_valid_q || pop;
	assign out_load     = slot_free && ((st_q == B_FRAC && !is_range_q) || st_q == B_R3);

	// span = high + 1 - low at 34 bits, then sign and magnitude
	assign span     = {{2{req.range_high[31]}}, req.range_high} + 34'd1
	                - {{2{req.range_low[31]}}, req.range_low};
	assign span_mag = span[33] ? (34'd0 - span) : span;

	// shared 33x33 multiplier
	always_comb begin
		case (st_q)
			B_M0: begin
				mul_a = {1'b0, s_q[31:0]};
				mul_b = {1'b0, MULT_CONST[31:0]};
			end
			B_M1: begin
				mul_a = {1'b0, s_q[31:0]};
				mul_b = {1'b0, MULT_CONST[63:32]};
			end
			B_M2: begin
				mul_a = {1'b0, s_q[63:32]};
				mul_b = {1'b0, MULT_CONST[31:0]};
			end
			B_FRAC: begin
				mul_a = {7'd0, acc_q[63:38]};
				mul_b = m_q;
			end
			B_R1: begin
				mul_a = {7'd0, frac_q[25:0]};
				mul_b = m_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// floor(frac * span / 2^52), low 32 bits
	assign q32         = a_q[57:26] + {24'd0, low_q[59:52]};
	assign rem         = |low_q[51:0];
	assign q32_up      = q32 + {31'd0, rem};
	assign ranged_next = neg_q ? (lo_q - q32_up) : (lo_q + q32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			out_valid_q <= 1'b0;
			s_q         <= '0;
			is_range_q  <= 1'b0;
			lo_q        <= '0;
			neg_q       <= 1'b0;
			m_q         <= '0;
			prod_q      <= '0;
			acc_q       <= '0;
			frac_q      <= '0;
			a_q         <= '0;
			low_q       <= '0;
			fraction_q  <= '0;
			ranged_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				B_IDLE: begin
					if (req_valid) begin
						s_q        <= req.gen_state;
						is_range_q <= req.is_range;
						lo_q       <= req.range_low;
						neg_q      <= span[33];
						m_q        <= span_mag[32:0];
						st_q       <= B_M0;
					end
				end
				B_M0: begin
					prod_q <= mul_p;
					st_q   <= B_M1;
				end
				B_M1: begin
					acc_q  <= prod_q[63:0];
					prod_q <= mul_p;
					st_q   <= B_M2;
				end
				B_M2: begin
					acc_q  <= acc_q + {prod_q[31:0], 32'd0};
					prod_q <= mul_p;
					st_q   <= B_M3;
				end
				B_M3: begin
					acc_q <= acc_q + {prod_q[31:0], 32'd0};
					st_q  <= B_FRAC;
				end
				B_FRAC: begin
					frac_q <= acc_q[63:12];
					prod_q <= mul_p;
					if (is_range_q) begin
						st_q <= B_R1;
					end else if (slot_free) begin
						fraction_q <= acc_q[63:12];
						ranged_q   <= '0;
						st_q       <= B_IDLE;
					end
				end
				B_R1: begin
					a_q    <= prod_q[58:0];
					prod_q <= mul_p;
					st_q   <= B_R2;
				end
				B_R2: begin
					low_q <= 60'({a_q[25:0], 26'd0}) + 60'(prod_q[58:0]);
					st_q  <= B_R3;
				end
				B_R3: begin
					if (slot_free) begin
						fraction_q <= frac_q;
						ranged_q   <= ranged_next;
						st_q       <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/xorshift_random_range_generator.sv]
// xorshift64* random generator with fraction and integer-range requests. A seed
// request (operation 0) loads the 64-bit state with a shift/add hash of the
// sign-extended seed and returns nothing; the first hash step runs at the accept
// edge and full then stays high while the remaining steps run.
// A next request (1) advances the state by
// three xor-shifts and returns the top 52 bits of state * 2685821657736338717
// as fraction (ranged_value is 0). A range request (2) does the same and also
// returns range_low + floor(fraction * (range_high + 1 - range_low) / 2^52),
// exact, wrapped to 32 bits. Code 3 is dropped. The front end takes one request
// per cycle while full is low and queues it (QUEUE_DEPTH entries); the back end
// works one request at a time on a single shared 33x33 multiplier, so that
// multiplier sets the sustained rate. Results wait in a one-entry output
// register, and the front keeps accepting meanwhile.
module xorshift_random_range_generator
	import xrrg_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4 // request queue entries, 2 or more
) (
	input  logic               clk,
	input  logic               arst_n,
	// request side
	input  logic               push,
	output logic               full,
	input  logic [1:0]         operation,
	input  logic signed [31:0] seed_value,
	input  logic signed [31:0] range_low,
	input  logic signed [31:0] range_high,
	// result side
	output logic               empty,
	input  logic               pop,
	output logic [51:0]        fraction,
	output logic signed [31:0] ranged_value
);

	// front -> queue
	logic req_wr;
	req_t req_in;
	logic queue_full;

	// queue -> back
	logic req_valid;
	logic req_pop;
	req_t req_out;

	// Front: owns the generator state, hashes seeds, steps the state
	// and queues next/range requests with the advanced state.
	xrrg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (operation),
		.seed_value (seed_value),
		.range_low  (range_low),
		.range_high (range_high),
		.queue_full (queue_full),
		.req_wr     (req_wr),
		.req        (req_in)
	);

	// Short queue decoupling the two halves.
	xrrg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (req_wr),
		.wr_data  (req_in),
		.full     (queue_full),
		.rd       (req_pop),
		.rd_data  (req_out),
		.nonempty (req_valid)
	);

	// Back: scrambling multiply, range scaling, output register.
	xrrg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req          (req_out),
		.req_pop      (req_pop),
		.empty        (empty),
		.pop          (pop),
		.fraction     (fraction),
		.ranged_value (ranged_value)
	);

endmodule

[rtl/core/xrrg_checker.sv]
module xrrg_checker
	import xrrg_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic [1:0]         operation,
	input logic               empty,
	input logic               pop,
	input logic [51:0]        fraction,
	input logic signed [31:0] ranged_value
);

	logic [15:0] outstanding_q;
	logic        inc;
	logic        dec;

	assign inc = push && !full && (operation == OP_NEXT || operation == OP_RANGE);
	assign dec = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({inc, dec})
				2'b10:   outstanding_q <= outstanding_q + 1'b1;
				2'b01:   outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	// waiting result holds until popped
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(fraction) && $stable(ranged_value)))
		else $error("result changed or vanished without pop");

	// seed hash blocks new requests while it runs
	a_seed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && operation == OP_SEED) |=> full ##1 full ##1 full)
		else $error("request accepted during seed hash");

	// no result without an accepted next/range request behind it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (outstanding_q != '0))
		else $error("result shown with no outstanding request");

endmodule

bind xorshift_random_range_generator xrrg_checker u_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Checks the xorshift64* range generator against its own predictor.
// Requests go in through a push/full queue port and results come back
// through an empty/pop port. The predictor keeps its own copy of the
// 64-bit generator state. It pushes one expected result for every
// fraction or range request that the block accepts. The monitor pops
// results and compares them in order.
module tb_top;
	import xrrg_pkg::*;

	// unused operation code: the block drops it without touching the state
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// output scrambler of xorshift64*
	localparam logic [63:0] SCRAMBLE_MUL = 64'd2685821657736338717;

	// largest range_high the block is specified for
	localparam logic signed [31:0] HIGH_CAP = 32'sh7FFF_FFFE;
	localparam logic signed [31:0] INT_MIN  = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX  = 32'sh7FFF_FFFF;

	localparam int RANDOM_REQS = 600;
	localparam int STALL_LIMIT = 2000; // cycles with no handshake on either side
	localparam int REPORT_MAX  = 10;

	typedef struct {
		logic [1:0]         operation;
		logic signed [31:0] seed_value;
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
		bit                 drain_first; // hold off until every result is back
	} draw_req_t;

	typedef struct {
		logic [51:0]        frac;
		logic signed [31:0] ranged;
	} draw_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [1:0]         operation = OP_SEED;
	logic signed [31:0] seed_value = '0;
	logic signed [31:0] range_low = '0;
	logic signed [31:0] range_high = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [51:0]        fraction;
	logic signed [31:0] ranged_value;

	draw_req_t pending_reqs[$]; // requests not yet taken by the block
	draw_t     expected_draws[$]; // results predicted but not yet popped
	logic [63:0] model_state;

	int fail_count = 0;
	int draws_checked = 0;
	int idle_cycles = 0;
	int n_seed = 0, n_next = 0, n_range = 0, n_unused = 0;

	// sender burst shaping and receiver stall pattern
	int burst_left = 1;
	int gap_left = 0;
	logic [31:0] pop_pattern = '1;
	int pattern_age = 0;

	xorshift_random_range_generator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.seed_value   (seed_value),
		.range_low    (range_low),
		.range_high   (range_high),
		.empty        (empty),
		.pop          (pop),
		.fraction     (fraction),
		.ranged_value (ranged_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// 64-bit shift/add integer hash used for seeding
	function automatic logic [63:0] seed_hash(input logic [63:0] key);
		logic [63:0] k;
		k = key;
		k = ~k + (k << 21);
		k = k ^ (k >> 24);
		k = k + (k << 3) + (k << 8);
		k = k ^ (k >> 14);
		k = k + (k << 2) + (k << 4);
		k = k ^ (k >> 28);
		k = k + (k << 31);
		return k;
	endfunction

	function automatic logic [63:0] xorshift_step(input logic [63:0] s);
		logic [63:0] t;
		t = s ^ (s >> 12);
		t = t ^ (t << 25);
		t = t ^ (t >> 27);
		return t;
	endfunction

	function automatic logic signed [31:0] cap_high(input logic signed [31:0] v);
		return (v == INT_MAX) ? HIGH_CAP : v;
	endfunction

	// Advance the model on one accepted request and queue what it returns.
	// The range value is floor(frac * span / 2^52) done at full width, so a
	// negative span (high below low) rounds toward minus infinity, and the
	// sum with low wraps to 32 bits.
	task automatic predict_draw(input draw_req_t req);
		logic [63:0]         scrambled;
		longint              span;
		logic signed [127:0] wide_frac;
		logic signed [127:0] wide_span;
		logic signed [127:0] scaled;
		draw_t               d;
		case (req.operation)
			OP_SEED: begin
				model_state = seed_hash({{32{req.seed_value[31]}}, req.seed_value});
			end
			OP_NEXT, OP_RANGE: begin
				model_state = xorshift_step(model_state);
				scrambled = model_state * SCRAMBLE_MUL;
				d.frac = scrambled[63:12];
				d.ranged = '0;
				if (req.operation == OP_RANGE) begin
					span = longint'(req.range_high) + 64'sd1 - longint'(req.range_low);
					wide_frac = {76'd0, d.frac};
					wide_span = span;
					scaled = (wide_frac * wide_span) >>> 52;
					d.ranged = req.range_low + scaled[31:0];
				end
				expected_draws.push_back(d);
			end
			default: begin
				// unused code: state and result queue untouched
			end
		endcase
	endtask

	task automatic queue_req(input logic [1:0] op, input logic signed [31:0] sv,
	                         input logic signed [31:0] lo, input logic signed [31:0] hi,
	                         input bit drain);
		draw_req_t r;
		r.operation = op;
		r.seed_value = sv;
		r.range_low = lo;
		r.range_high = hi;
		r.drain_first = drain;
		pending_reqs.push_back(r);
		case (op)
			OP_SEED:  n_seed++;
			OP_NEXT:  n_next++;
			OP_RANGE: n_range++;
			default:  n_unused++;
		endcase
	endtask

	// Driver: presents the head of pending_reqs in bursts with random gaps.
	// A request stays on the port until it is taken. Between requests the
	// payload carries junk, which the block must ignore while push is low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			operation <= OP_SEED;
			seed_value <= '0;
			range_low <= '0;
			range_high <= '0;
		end else begin
			if (push && !full) begin
				predict_draw(pending_reqs[0]);
				pending_reqs.delete(0);
			end
			if (!(push && full)) begin
				if (gap_left == 0 && pending_reqs.size() != 0 &&
				    !(pending_reqs[0].drain_first && expected_draws.size() != 0)) begin
					push <= 1'b1;
					operation <= pending_reqs[0].operation;
					seed_value <= pending_reqs[0].seed_value;
					range_low <= pending_reqs[0].range_low;
					range_high <= pending_reqs[0].range_high;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						// about a quarter of the bursts run straight into the next one
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end else begin
					if (gap_left != 0)
						gap_left--;
					push <= 1'b0;
					operation <= 2'($urandom);
					seed_value <= $urandom;
					range_low <= $urandom;
					range_high <= $urandom;
				end
			end
		end
	end

	task automatic check_draw(input logic [51:0] f, input logic signed [31:0] r);
		draw_t want;
		if (expected_draws.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_MAX)
				$display("%0t: result with nothing expected: fraction=%h ranged_value=%0d",
				         $time, f, r);
		end else begin
			want = expected_draws.pop_front();
			draws_checked++;
			if (f !== want.frac || r !== want.ranged) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("%0t: result %0d: fraction %h (want %h), ranged_value %0d (want %0d)",
					         $time, draws_checked, f, want.frac, r, want.ranged);
			end
		end
	endtask

	// Monitor: pops on a rotating 32-bit stall pattern, redrawn after each
	// full rotation. The patterns range from no stalls at all to mostly stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				check_draw(fraction, ranged_value);
			pop <= pop_pattern[0];
			if (pattern_age == 31) begin
				pattern_age = 0;
				case ($urandom_range(0, 3))
					0: pop_pattern = '1;
					1: pop_pattern = $urandom;
					2: pop_pattern = $urandom | $urandom;
					default: pop_pattern = $urandom & $urandom;
				endcase
			end else begin
				pattern_age++;
				pop_pattern = {pop_pattern[0], pop_pattern[31:1]};
			end
		end
	end

	// count cycles in which neither side completes a handshake
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("%0t: no progress for %0d cycles, %0d requests and %0d results outstanding",
		         $time, STALL_LIMIT, pending_reqs.size(), expected_draws.size());
		$display("[xorshift_random_range_generator] ERROR");
		$finish;
	end

	initial begin : stimulus
		int                 counted;
		int                 pick;
		logic [1:0]         op;
		logic signed [31:0] sv;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		longint             top;
		bit                 drain;

		model_state = seed_hash(64'd0);

		// Directed part.
		// draws straight from the reset state
		queue_req(OP_RANGE, 0, -100, 100, 1'b0);
		queue_req(OP_NEXT, 0, 0, 0, 1'b0);
		// seed extremes, each but INT_MIN followed by a draw
		queue_req(OP_SEED, 0, 0, 0, 1'b0);
		queue_req(OP_NEXT, 0, 0, 0, 1'b0);
		queue_req(OP_SEED, -1, 0, 0, 1'b0);
		queue_req(OP_NEXT, 0, 0, 0, 1'b0);
		queue_req(OP_SEED, INT_MAX, 0, 0, 1'b0);
		queue_req(OP_RANGE, 0, INT_MIN, HIGH_CAP, 1'b0); // widest span
		queue_req(OP_SEED, INT_MIN, 0, 0, 1'b0);
		queue_req(OP_SEED, 1, 0, 0, 1'b0);               // back-to-back seeds
		queue_req(OP_RANGE, 0, 0, 0, 1'b0);              // span of one
		queue_req(OP_RANGE, 0, INT_MIN, INT_MIN, 1'b0);
		queue_req(OP_RANGE, 0, HIGH_CAP, HIGH_CAP, 1'b0);
		queue_req(OP_RANGE, 0, 17, 16, 1'b0);            // high just below low: zero span
		queue_req(OP_RANGE, 0, INT_MAX, HIGH_CAP, 1'b0); // zero span at the top
		queue_req(OP_RANGE, 0, 5, -5, 1'b0);             // small negative span
		queue_req(OP_RANGE, 0, INT_MAX, INT_MIN, 1'b0);  // most negative span, wraps
		queue_req(OP_RANGE, 0, INT_MIN, -1, 1'b0);
		queue_req(OP_RANGE, 0, -1, HIGH_CAP, 1'b0);
		// unused code must leave the state alone; the next draw shows it
		queue_req(OP_UNUSED, -1, -1, -1, 1'b1);
		queue_req(OP_NEXT, 0, 0, 0, 1'b0);
		queue_req(OP_UNUSED, 0, 0, 0, 1'b0);
		queue_req(OP_RANGE, 0, -1000, 1000, 1'b0);

		// Random part. Unused codes come on top of the count.
		counted = 0;
		while (counted < RANDOM_REQS) begin
			// drain the block completely now and then
			drain = (counted % 150 == 0);
			pick = $urandom_range(0, 99);
			if (pick < 10)      op = OP_SEED;
			else if (pick < 45) op = OP_NEXT;
			else if (pick < 95) op = OP_RANGE;
			else                op = OP_UNUSED;
			sv = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 0) ? INT_MIN : INT_MAX)
			                                 : $signed($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					lo = $urandom;
					hi = cap_high($urandom);
				end
				4, 5, 6: begin
					lo = $urandom;
					top = longint'(lo) + $urandom_range(0, 1000);
					if (top > longint'(HIGH_CAP))
						top = longint'(HIGH_CAP);
					hi = top[31:0];
				end
				7: begin
					lo = cap_high($urandom);
					hi = lo;
				end
				8: begin
					lo = -$signed($urandom_range(0, 50));
					hi = $urandom_range(0, 50);
				end
				default: begin
					case ($urandom_range(0, 3))
						0: lo = INT_MIN;
						1: lo = INT_MAX;
						2: lo = 0;
						default: lo = -1;
					endcase
					case ($urandom_range(0, 3))
						0: hi = INT_MIN;
						1: hi = HIGH_CAP;
						2: hi = 0;
						default: hi = -1;
					endcase
				end
			endcase
			queue_req(op, sv, lo, hi, drain);
			if (op != OP_UNUSED)
				counted++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || expected_draws.size() != 0)
			@(posedge clk);
		// let any trailing seed finish and catch stray results
		repeat (40) @(posedge clk);

		if (expected_draws.size() != 0)
			$display("%0d expected results never arrived", expected_draws.size());
		$display("covered %0d requests: %0d seeds, %0d fraction draws, %0d range draws,",
		         n_seed + n_next + n_range + n_unused, n_seed, n_next, n_range);
		$display("%0d unused codes; %0d results compared, %0d failures",
		         n_unused, draws_checked, fail_count);
		if (fail_count == 0 && expected_draws.size() == 0)
			$display("[xorshift_random_range_generator] OK");
		else
			$display("[xorshift_random_range_generator] ERROR");
		$finish;
	end

endmodule
